@@ src/tlife_pkg.sv @@
package tlife_pkg;

  localparam int unsigned MAX_DIM = 128;
  localparam int unsigned CELLS   = MAX_DIM * MAX_DIM;
  localparam int unsigned AW      = $clog2(CELLS);
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned K_W     = $clog2(MAX_DIM + 2);
  localparam int unsigned GEN_W   = 16;
  localparam int unsigned CFG_W   = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_RUN  = 2'd1,
    FUNC_READ = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_ROWS        = 2'd0,
    CFG_COLS        = 2'd1,
    CFG_GENERATIONS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_UP  = 2'd0,
    PH_MID = 2'd1,
    PH_DN  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_DRAIN,
    ST_COPY
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [7:0] v);
    logic [DIM_W-1:0] r;
    if (v == 8'd0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

@@ src/toroidal_life_automaton.sv @@
// Game of Life (birth on three, survival on two or three) on a rows by cols torus of up to
// 128 by 128 cells. Load items write cells in row-major order and read items return them in
// the same order, one item per cycle while the block is idle and no result is held back,
// with tlast on the final cell. The grid lives in one memory of two banks with a single
// read port; a generation reads one bank and writes the other, fetching each column of the
// three-row window with three reads. A run item repeats that for the configured number of
// generations and stops early once a generation changes no cell. When the final grid lies
// in the second bank, it is copied back, so cells outside the active rows by cols area keep
// what was loaded there. The run then returns one completion item with tuser set. No
// clearing pass follows reset; configuration writes are taken at any time but must only be
// made while the block is idle.
module toroidal_life_automaton
  import tlife_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] cell_in
  input  logic [1:0]       s_axis_tuser,   // [1:0] func
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] cell_out
  output logic             m_axis_tuser,   // [0] is_done
  output logic             m_axis_tlast,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [7:0]       rows_q, cols_q;
  logic [GEN_W-1:0] gens_q;
  state_e           state_q, state_d;

  logic [DIM_W-1:0] nr, nc;
  logic [CNT_W-1:0] total;

  logic [AW-1:0]    lptr_q, rptr_q, lptr_eff, rptr_eff, lptr_nxt, rptr_nxt;
  logic [CNT_W-1:0] lptr_inc, rptr_inc;

  logic             m_valid_q, m_done_q, m_last_q;
  logic             bank_q;

  logic [DIM_W-1:0] row_q, col_q;
  logic [K_W-1:0]   k_q;
  phase_e           ph_q;
  logic [AW-1:0]    up_q, mid_q, dn_q;
  logic [CNT_W-1:0] dn_sum;
  logic [GEN_W:0]   gcnt_inc;
  logic [GEN_W-1:0] gcnt_q;

  logic             tag_vld_q, tag_wr_q, tag_end_q;
  phase_e           tag_ph_q;
  logic [AW-1:0]    tag_waddr_q;

  logic             cu_q, cm_q;
  logic [2:0]       wa_q, wb_q, wnew;
  logic [3:0]       ncount;
  logic             nv, cell_chg, changed_q, changed_any;

  logic [CNT_W-1:0] cp_q;
  logic             cp_rd, cp_wr, copy_end, need_copy;
  logic [AW-1:0]    cp_waddr;

  logic             mem_we, mem_re, mem_wdata, mem_rd_q;
  logic [AW:0]      mem_waddr, mem_raddr;
  logic             grid_q [2*CELLS];

  logic             s_accept, run_start, load_acc, read_acc;
  func_e            func;
  logic             issue_en, issue_last, row_end, gen_init, done_pulse, more;
  logic [AW-1:0]    issue_base;

  assign nr    = clamp_dim(rows_q);
  assign nc    = clamp_dim(cols_q);
  assign total = CNT_W'(nr * nc);

  assign func      = func_e'(s_axis_tuser);
  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign load_acc  = s_accept && (func == FUNC_LOAD);
  assign run_start = s_accept && (func == FUNC_RUN);
  assign read_acc  = s_accept && (func == FUNC_READ);

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_done_q ? 1'b0 : mem_rd_q};
  assign m_axis_tuser  = m_done_q;
  assign m_axis_tlast  = m_last_q;

  assign lptr_eff = ({1'b0, lptr_q} >= total) ? '0 : lptr_q;
  assign rptr_eff = ({1'b0, rptr_q} >= total) ? '0 : rptr_q;
  assign lptr_inc = {1'b0, lptr_eff} + CNT_W'(1);
  assign rptr_inc = {1'b0, rptr_eff} + CNT_W'(1);
  assign lptr_nxt = (lptr_inc >= total) ? '0 : lptr_inc[AW-1:0];
  assign rptr_nxt = (rptr_inc >= total) ? '0 : rptr_inc[AW-1:0];

  assign row_end    = (ph_q == PH_DN) && (k_q == K_W'(nc) + K_W'(1));
  assign issue_last = row_end && (row_q == nc - nc + nr - DIM_W'(1));
  assign dn_sum     = CNT_W'(dn_q) + CNT_W'(nc);
  assign gcnt_inc   = {1'b0, gcnt_q} + (GEN_W+1)'(1);

  always_comb begin
    unique case (ph_q)
      PH_UP:   issue_base = up_q;
      PH_MID:  issue_base = mid_q;
      PH_DN:   issue_base = dn_q;
      default: issue_base = mid_q;
    endcase
  end

  assign wnew   = {cu_q, cm_q, mem_rd_q};
  assign ncount = 4'(wa_q[2]) + 4'(wa_q[1]) + 4'(wa_q[0]) + 4'(wb_q[2]) + 4'(wb_q[0])
                + 4'(wnew[2]) + 4'(wnew[1]) + 4'(wnew[0]);
  assign nv          = (ncount == 4'd3) || ((ncount == 4'd2) && wb_q[1]);
  assign cell_chg    = tag_vld_q && tag_wr_q && (tag_ph_q == PH_DN) && (nv != wb_q[1]);
  assign changed_any = changed_q || cell_chg;
  assign more        = changed_any && (gcnt_inc < {1'b0, gens_q});

  assign need_copy = changed_any && !bank_q;
  assign cp_rd     = (state_q == ST_COPY) && (cp_q < total);
  assign cp_wr     = (state_q == ST_COPY) && (cp_q != '0);
  assign copy_end  = (state_q == ST_COPY) && (cp_q == total);
  assign cp_waddr  = AW'(cp_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (run_start && (gens_q != '0)) state_d = ST_GEN;
      end
      ST_GEN: begin
        if (issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (more) begin
          state_d = ST_GEN;
        end else if (need_copy) begin
          state_d = ST_COPY;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (copy_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    issue_en   = 1'b0;
    gen_init   = 1'b0;
    done_pulse = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        gen_init   = run_start && (gens_q != '0);
        done_pulse = run_start && (gens_q == '0);
      end
      ST_GEN: begin
        issue_en = 1'b1;
      end
      ST_DRAIN: begin
        gen_init   = more;
        done_pulse = !more && !need_copy;
      end
      ST_COPY: begin
        done_pulse = copy_end;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_re    = issue_en || cp_rd || read_acc;
    mem_raddr = issue_en ? {bank_q, issue_base + AW'(col_q)} :
                cp_rd    ? {1'b1, cp_q[AW-1:0]} : {bank_q, rptr_eff};
    mem_we    = load_acc || cp_wr || (tag_vld_q && tag_wr_q && (tag_ph_q == PH_DN));
    mem_waddr = load_acc ? {bank_q, lptr_eff} :
                cp_wr    ? {1'b0, cp_waddr} : {~bank_q, tag_waddr_q};
    mem_wdata = load_acc ? s_axis_tdata[0] : (cp_wr ? mem_rd_q : nv);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rd_q <= grid_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 8'd1;
      cols_q <= 8'd1;
      gens_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROWS:        rows_q <= cfg_data_i[7:0];
        CFG_COLS:        cols_q <= cfg_data_i[7:0];
        CFG_GENERATIONS: gens_q <= cfg_data_i[GEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lptr_q    <= '0;
      rptr_q    <= '0;
      m_valid_q <= 1'b0;
      m_done_q  <= 1'b0;
      m_last_q  <= 1'b0;
      bank_q    <= 1'b0;
      tag_vld_q <= 1'b0;
      changed_q <= 1'b0;
      gcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      tag_vld_q <= issue_en;
      if (load_acc) lptr_q <= lptr_nxt;
      if (read_acc) rptr_q <= rptr_nxt;
      if (run_start) begin
        lptr_q <= '0;
        rptr_q <= '0;
        gcnt_q <= '0;
      end
      if (read_acc || done_pulse) begin
        m_valid_q <= 1'b1;
        m_done_q  <= done_pulse;
        m_last_q  <= read_acc && ({1'b0, rptr_eff} == total - CNT_W'(1));
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (gen_init) begin
        changed_q <= 1'b0;
      end else if (cell_chg) begin
        changed_q <= 1'b1;
      end
      if (state_q == ST_DRAIN) begin
        bank_q <= more ? ~bank_q : 1'b0;
        gcnt_q <= gcnt_inc[GEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_init) begin
      row_q <= '0;
      col_q <= nc - DIM_W'(1);
      k_q   <= '0;
      ph_q  <= PH_UP;
      up_q  <= AW'(total - CNT_W'(nc));
      mid_q <= '0;
      dn_q  <= (nr == DIM_W'(1)) ? '0 : AW'(nc);
    end else if (issue_en) begin
      unique case (ph_q)
        PH_UP:   ph_q <= PH_MID;
        PH_MID:  ph_q <= PH_DN;
        default: ph_q <= PH_UP;
      endcase
      if (row_end) begin
        k_q   <= '0;
        col_q <= nc - DIM_W'(1);
        row_q <= row_q + DIM_W'(1);
        up_q  <= mid_q;
        mid_q <= dn_q;
        dn_q  <= (dn_sum >= total) ? '0 : dn_sum[AW-1:0];
      end else if (ph_q == PH_DN) begin
        k_q   <= k_q + K_W'(1);
        col_q <= (col_q == nc - DIM_W'(1)) ? '0 : col_q + DIM_W'(1);
      end
    end
    if (state_q == ST_DRAIN) begin
      cp_q <= '0;
    end else if (state_q == ST_COPY) begin
      cp_q <= cp_q + CNT_W'(1);
    end
    if (issue_en) begin
      tag_ph_q    <= ph_q;
      tag_wr_q    <= (ph_q == PH_DN) && (k_q >= K_W'(2));
      tag_waddr_q <= mid_q + AW'(k_q - K_W'(2));
      tag_end_q   <= issue_last;
    end
    if (tag_vld_q) begin
      unique case (tag_ph_q)
        PH_UP:  cu_q <= mem_rd_q;
        PH_MID: cm_q <= mem_rd_q;
        PH_DN: begin
          wa_q <= wb_q;
          wb_q <= wnew;
        end
        default: ;
      endcase
    end
  end

  a_tag_from_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_vld_q |-> $past(state_q == ST_GEN))
    else $error("window data tagged without a preceding engine read");

  a_final_tag_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (tag_vld_q && tag_end_q && tag_wr_q))
    else $error("generation ended without its final cell write");

  a_bank_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re && (state_q != ST_IDLE)) |-> (mem_waddr[AW] != mem_raddr[AW]))
    else $error("engine wrote the bank it is reading");

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_start && (gens_q != '0)) |=> (state_q == ST_GEN))
    else $error("run item did not start a generation");

  a_done_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tlast && (m_axis_tdata == 8'd0)))
    else $error("completion item carries cell data");

  a_fetch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN) |-> ({1'b0, k_q} <= (K_W+1)'(nc) + (K_W+1)'(1)))
    else $error("column fetch count ran past the row");

endmodule

@@ tb/toroidal_life_automaton_tb.sv @@
module toroidal_life_automaton_tb;
  import tlife_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned SCRIPT_LEN = 28;

  typedef struct packed {
    logic alive;
    logic done;
    logic last;
  } cell_result_t;

  typedef struct packed {
    logic is_cfg;
    cfg_idx_e reg_sel;
    logic [CFG_W-1:0] value;
    logic [1:0] func;
    logic cell_in;
    logic typed;
    cell_result_t want;
  } script_row_t;

  typedef enum logic [1:0] {
    PACE_OPEN,
    PACE_COIN,
    PACE_QUARTER,
    PACE_MOSTLY
  } pace_e;

  localparam cell_result_t RUN_DONE   = '{alive: 1'b0, done: 1'b1, last: 1'b0};
  localparam cell_result_t LAST_ALIVE = '{alive: 1'b1, done: 1'b0, last: 1'b1};
  localparam cell_result_t LAST_DEAD  = '{alive: 1'b0, done: 1'b0, last: 1'b1};
  localparam cell_result_t MID_DEAD   = '{alive: 1'b0, done: 1'b0, last: 1'b0};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  // Shadow of the automaton.
  bit           grid_now [CELLS];
  bit           grid_prev [CELLS];
  int unsigned  load_at = 0;
  int unsigned  read_at = 0;
  logic [7:0]   rows_q = 8'd1;
  logic [7:0]   cols_q = 8'd1;
  logic [15:0]  gens_q = 16'd0;

  cell_result_t pending_cells [$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  burst_left = 0;
  bit           hold_off_req = 1'b0;
  bit           hold_off_done = 1'b0;
  script_row_t  script [SCRIPT_LEN];

  toroidal_life_automaton dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned dim_of(input logic [7:0] v);
    int unsigned d;
    d = v;
    if (d == 0) begin
      d = 1;
    end else if (d > MAX_DIM) begin
      d = MAX_DIM;
    end
    return d;
  endfunction

  function automatic bit life_generation(input int unsigned nr, input int unsigned nc);
    int unsigned i, r, c, dr, dc, n;
    logic nv;
    bit changed;
    changed = 1'b0;
    for (i = 0; i < nr * nc; i++) begin
      grid_prev[i] = grid_now[i];
    end
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        n = 0;
        for (dr = 0; dr < 3; dr++) begin
          for (dc = 0; dc < 3; dc++) begin
            if ((dr != 1 || dc != 1) &&
                grid_prev[((r + nr + dr - 1) % nr) * nc + (c + nc + dc - 1) % nc]) begin
              n++;
            end
          end
        end
        nv = grid_prev[r * nc + c];
        if (n < 2 || n > 3) begin
          nv = 1'b0;
        end
        if (n == 3) begin
          nv = 1'b1;
        end
        if (nv != grid_prev[r * nc + c]) begin
          changed = 1'b1;
        end
        grid_now[r * nc + c] = nv;
      end
    end
    return changed;
  endfunction

  function automatic bit life_apply(input logic [1:0] f, input logic c,
                                    output cell_result_t res);
    int unsigned nr, nc, total, g;
    bit moving, has;
    nr = dim_of(rows_q);
    nc = dim_of(cols_q);
    total = nr * nc;
    res = '0;
    has = 1'b0;
    case (f)
      FUNC_LOAD: begin
        if (load_at >= total) begin
          load_at = 0;
        end
        grid_now[load_at] = c;
        load_at = (load_at + 1 >= total) ? 0 : load_at + 1;
      end
      FUNC_RUN: begin
        moving = 1'b1;
        for (g = 0; g < gens_q; g++) begin
          if (moving) begin
            moving = life_generation(nr, nc);
          end
        end
        load_at = 0;
        read_at = 0;
        res.done = 1'b1;
        has = 1'b1;
      end
      FUNC_READ: begin
        if (read_at >= total) begin
          read_at = 0;
        end
        res.alive = grid_now[read_at];
        res.last = (read_at == total - 1);
        read_at = (read_at + 1 >= total) ? 0 : read_at + 1;
        has = 1'b1;
      end
      default: begin
      end
    endcase
    return has;
  endfunction

  function automatic script_row_t cfg_row(input cfg_idx_e idx, input logic [CFG_W-1:0] v);
    script_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_sel = idx;
    s.value = v;
    return s;
  endfunction

  function automatic script_row_t op_row(input logic [1:0] f, input logic c,
                                         input logic typed, input cell_result_t want);
    script_row_t s;
    s = '0;
    s.func = f;
    s.cell_in = c;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 50) begin
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    end
    mismatches++;
  endtask

  task automatic offer_item(input logic [1:0] f, input logic c, input bit typed,
                            input cell_result_t want);
    int unsigned gap;
    cell_result_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= {7'b0, c};
    do @(posedge clk_i); while (!s_axis_tready);
    if (life_apply(f, c, predicted)) begin
      pending_cells.push_back(typed ? want : predicted);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cells.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Loads give no result, so the block is left to finish the last one after the results drain.
  task automatic settle_block();
    drain_results();
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROWS:        rows_q = v[7:0];
      CFG_COLS:        cols_q = v[7:0];
      CFG_GENERATIONS: gens_q = v[15:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic offer_op(input logic [1:0] f, input logic c);
    if ($urandom_range(0, 19) == 0) begin
      offer_item(FUNC_NONE, 1'($urandom_range(0, 1)), 1'b0, '0);
    end
    if ($urandom_range(0, 99) == 0) begin
      drain_results();
    end
    offer_item(f, c, 1'b0, '0);
    items_sent++;
  endtask

  task automatic load_cells(input int unsigned n);
    int unsigned density;
    density = $urandom_range(1, 3);
    repeat (n) offer_op(FUNC_LOAD, $urandom_range(0, 3) < density);
  endtask

  task automatic read_cells(input int unsigned n, input bit with_hold);
    if (with_hold) begin
      hold_off_req = 1'b1;
    end
    repeat (n) offer_op(FUNC_READ, 1'($urandom_range(0, 1)));
  endtask

  // Every phase first loads the whole grid, so no read ever reaches an unwritten cell.
  task automatic life_phase(input logic [7:0] r_raw, input logic [7:0] c_raw,
                            input logic [15:0] g, input bit with_hold);
    int unsigned total, budget, used, k, pick;
    bit fresh;
    settle_block();
    write_reg(CFG_COLS, {8'($urandom_range(0, 255)), c_raw});
    write_reg(CFG_GENERATIONS, g);
    write_reg(CFG_ROWS, {8'($urandom_range(0, 255)), r_raw});
    total = dim_of(rows_q) * dim_of(cols_q);
    budget = (2 * total + 1 > 96) ? 2 * total + 1 : 96;
    load_cells(total);
    used = total;
    fresh = 1'b1;
    while (used < budget) begin
      pick = $urandom_range(0, 9);
      if (with_hold || pick < 7) begin
        if (!fresh) begin
          load_cells(total);
          used += total;
        end
        offer_op(FUNC_RUN, 1'($urandom_range(0, 1)));
        read_cells(total, with_hold);
        with_hold = 1'b0;
        used += total + 1;
      end else if (pick == 7) begin
        k = $urandom_range(1, total);
        load_cells(k);
        used += k;
      end else if (pick == 8) begin
        k = $urandom_range(1, total);
        read_cells(k, 1'b0);
        used += k;
      end else begin
        offer_op(FUNC_RUN, 1'($urandom_range(0, 1)));
        used++;
      end
      fresh = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("result item with nothing expected", 1, 0);
      end else begin
        want = pending_cells.pop_front();
        if (m_axis_tdata[0] !== want.alive) begin
          report_mismatch("cell_out", int'(m_axis_tdata[0]), int'(want.alive));
        end
        if (m_axis_tuser !== want.done) begin
          report_mismatch("is_done", int'(m_axis_tuser), int'(want.done));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last_cell", int'(m_axis_tlast), int'(want.last));
        end
      end
    end
  end

  initial begin : sink_pacing
    pace_e mode;
    int unsigned mode_left, tick;
    m_axis_tready = 1'b0;
    mode = PACE_OPEN;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = pace_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        tick++;
        case (mode)
          PACE_OPEN:    m_axis_tready <= 1'b1;
          PACE_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
          PACE_QUARTER: m_axis_tready <= (tick % 4 == 0);
          default:      m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FUNC_LOAD;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ROWS;
    cfg_data_i = '0;
    script = '{
      cfg_row(CFG_GENERATIONS, 16'd0),
      op_row(FUNC_RUN, 1'b0, 1'b1, RUN_DONE),
      op_row(FUNC_LOAD, 1'b1, 1'b0, '0),
      op_row(FUNC_READ, 1'b0, 1'b1, LAST_ALIVE),
      op_row(FUNC_NONE, 1'b1, 1'b0, '0),
      op_row(FUNC_READ, 1'b1, 1'b1, LAST_ALIVE),
      // A lone live cell on a one by one torus sees itself eight times and dies.
      cfg_row(CFG_GENERATIONS, 16'd1),
      op_row(FUNC_RUN, 1'b1, 1'b1, RUN_DONE),
      op_row(FUNC_READ, 1'b0, 1'b1, LAST_DEAD),
      cfg_row(CFG_ROWS, 16'hFF00),
      cfg_row(CFG_COLS, 16'd3),
      op_row(FUNC_LOAD, 1'b1, 1'b0, '0),
      op_row(FUNC_LOAD, 1'b1, 1'b0, '0),
      op_row(FUNC_LOAD, 1'b0, 1'b0, '0),
      op_row(FUNC_LOAD, 1'b1, 1'b0, '0),
      // The row dies out at once, so the long run stops early.
      cfg_row(CFG_GENERATIONS, 16'hFFFF),
      op_row(FUNC_RUN, 1'b0, 1'b1, RUN_DONE),
      op_row(FUNC_READ, 1'b0, 1'b1, MID_DEAD),
      op_row(FUNC_READ, 1'b0, 1'b1, MID_DEAD),
      op_row(FUNC_READ, 1'b0, 1'b1, LAST_DEAD),
      op_row(FUNC_LOAD, 1'b1, 1'b0, '0),
      op_row(FUNC_LOAD, 1'b1, 1'b0, '0),
      op_row(FUNC_READ, 1'b0, 1'b0, '0),
      op_row(FUNC_READ, 1'b0, 1'b0, '0),
      // Shrinking the grid leaves both pointers past its end.
      cfg_row(CFG_COLS, 16'd2),
      op_row(FUNC_LOAD, 1'b0, 1'b0, '0),
      op_row(FUNC_READ, 1'b0, 1'b0, '0),
      op_row(FUNC_READ, 1'b0, 1'b0, '0)
    };
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle_block();
        write_reg(script[i].reg_sel, script[i].value);
      end else begin
        offer_item(script[i].func, script[i].cell_in, script[i].typed, script[i].want);
      end
    end

    life_phase(8'd255, 8'd0, 16'd3, 1'b0);
    life_phase(8'd1, 8'd128, 16'd2, 1'b1);
    life_phase(8'd1, 8'd1, 16'hFFFF, 1'b0);
    life_phase(8'd1, 8'd3, 16'hFFFF, 1'b0);
    life_phase(8'd0, 8'd2, 16'hFFFF, 1'b0);
    life_phase(8'd3, 8'd3, 16'd0, 1'b0);
    while (items_sent < ITEM_TARGET) begin
      life_phase(8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)),
                 16'($urandom_range(0, 6)), 1'b0);
    end

    drain_results();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tlife_pkg.sv
src/toroidal_life_automaton.sv
tb/toroidal_life_automaton_tb.sv
